// ===== rtl/sbf_pkg.sv =====
package sbf_pkg;

   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_RADIUS = 7;
   localparam int unsigned MAX_HEIGHT = 1024;

   localparam int unsigned PIX_W   = 16;
   localparam int unsigned HS_W    = 20;
   localparam int unsigned CS_W    = 24;
   localparam int unsigned RECIP_W = 21;
   localparam int unsigned COORD_W = 10;
   localparam int unsigned DIM_W   = 11;
   localparam int unsigned RAD_W   = 3;
   localparam int unsigned FRAC_W  = 20;
   localparam int unsigned RECIP_LO_W = 11;

   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;
   localparam logic [RAD_W-1:0]   RADIUS_RESET = 3'd1;
   localparam logic [RECIP_W-1:0] RECIP_RESET  = 21'd116508;

   // register index = csr_paddr[3:2]
   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_RADIUS = 2'd2,
      REG_RECIP  = 2'd3
   } reg_index_type;

endpackage

// ===== rtl/sbf_ram.sv =====
module sbf_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/separable_box_filter.sv =====
// Streaming 2-D box filter, square window of side 2r+1, separable form.
// req_*: one 16-bit pixel per transaction, raster order. rsp_*: output pixels
// with their column and row; tlast marks the final output caused by one input
// pixel, tuser marks the last output pixel of the frame.
// csr_*: APB-style registers image_width (0x0), image_height (0x4),
// window_radius (0x8), area_reciprocal (0xC, Q1.20). Any write restarts the
// frame at row 0, column 0; write only while the filter is idle.
// Sequencing: each input pixel is accepted in S_IDLE; each column update runs
// S_ARD then S_AEX and each emitted output runs S_BRD, S_BEX, S_BMUL, S_BOUT,
// all through the read-modify-write sequencer around the column-sum and
// line-store memories. A mid-row pixel left of column r updates no column;
// one at or right of it updates one column and, once an output row is
// complete, emits one output; the last pixel of a row or frame walks up to
// 8 columns and 8 x 8 outputs. First output appears r rows and r columns after its input.
// Reset clears control state only; memories need no clearing pass since every
// entry is written in a frame before it is read.
// When rsp_tready is low while an output is held, the result register holds and the sequencer waits.
module separable_box_filter #(
   parameter int unsigned MAX_WIDTH  = sbf_pkg::MAX_WIDTH,
   parameter int unsigned MAX_RADIUS = sbf_pkg::MAX_RADIUS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] pixel_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [15:0] pixel_out, [25:16] out_column, [35:26] out_row
   output logic        rsp_tlast,
   output logic        rsp_tuser,    // [0] frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned XW  = $clog2(MAX_WIDTH);
   localparam int unsigned WCW = XW + 1;
   localparam int unsigned WIN = 2 * MAX_RADIUS + 1;
   localparam int unsigned WW  = $clog2(WIN);
   localparam int unsigned LSD = WIN << XW;
   localparam int unsigned PW  = sbf_pkg::PIX_W;
   localparam int unsigned HW  = sbf_pkg::HS_W;
   localparam int unsigned CW  = sbf_pkg::CS_W;
   localparam int unsigned YW  = sbf_pkg::COORD_W;
   localparam int unsigned LOW = sbf_pkg::RECIP_LO_W;
   localparam int unsigned HIW = sbf_pkg::RECIP_W - sbf_pkg::RECIP_LO_W;
   localparam int unsigned PRW = CW + sbf_pkg::RECIP_W + 1;
   localparam int unsigned FRAC_SH = sbf_pkg::FRAC_W;

   typedef enum logic [2:0] {
      S_IDLE, S_ARD, S_AEX, S_BRD, S_BEX, S_BMUL, S_BOUT
   } state_type;

   function automatic logic [WW-1:0] sub_mod(input logic [WW-1:0] a, input logic [3:0] k);
      logic [WW+1:0] t;
      t = (WW+2)'(a) + (WW+2)'(WIN) - (WW+2)'(k);
      if (t >= (WW+2)'(WIN)) begin
         t = t - (WW+2)'(WIN);
      end
      return WW'(t);
   endfunction

   function automatic sbf_pkg::reg_index_type reg_index_cast(input logic [1:0] a);
      return sbf_pkg::reg_index_type'(a);
   endfunction

   state_type state_ff, state_in;

   logic [sbf_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [sbf_pkg::DIM_W-1:0]   height_ff, height_in;
   logic [sbf_pkg::RAD_W-1:0]   radius_ff, radius_in;
   logic [sbf_pkg::RECIP_W-1:0] recip_ff, recip_in;

   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [WW-1:0] ymod_ff, ymod_in;
   logic [HW-1:0] hsum_ff, hsum_in;
   logic [PW-1:0] taps_ff [WIN];
   logic [PW-1:0] taps_in [WIN];

   logic [YW-1:0] cy_ff, cy_in;
   logic [WW-1:0] cymod_ff, cymod_in;
   logic [XW-1:0] x_ff, x_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [2:0]    d_ff, d_in;
   logic [YW-1:0] yy_ff, yy_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [WW-1:0] yymod_ff, yymod_in, y0mod_ff, y0mod_in;
   logic          rows_ff, rows_in;
   logic [CW-1:0] csv_ff, csv_in;
   logic [CW+LOW-1:0] plo_ff, plo_in;
   logic [CW+HIW-1:0] phi_ff, phi_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_user_ff, rsp_user_in;

   logic [WCW-1:0] w_eff;
   logic [sbf_pkg::DIM_W-1:0] h_eff;
   logic [3:0]     k2, r1;
   logic           accept, cfg_wr, out_free;

   logic [CW-1:0]  cs_rd, cs_wdata;
   logic [HW-1:0]  st_rd;
   logic           cs_we;
   logic [XW+WW-1:0] st_raddr, st_waddr;

   logic           lastcol, lastrow, col_ge_r, row_ge_r;
   logic [XW-1:0]  x0_acc;
   logic [YW-1:0]  y0_acc;
   logic [PW-1:0]  px;
   logic [PRW-1:0] prod;
   logic [PRW-FRAC_SH-1:0] quo;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign px         = req_tdata[PW-1:0];
   assign k2         = {radius_ff, 1'b1};
   assign r1         = 4'(radius_ff) + 4'd1;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WCW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = sbf_pkg::DIM_W'(1);
      end else if (32'(height_ff) > 32'(sbf_pkg::MAX_HEIGHT)) begin
         h_eff = sbf_pkg::DIM_W'(sbf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   always_comb begin
      unique case (reg_index_cast(csr_paddr[3:2]))
         sbf_pkg::REG_WIDTH:  csr_prdata = 32'(width_ff);
         sbf_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         sbf_pkg::REG_RADIUS: csr_prdata = 32'(radius_ff);
         sbf_pkg::REG_RECIP:  csr_prdata = 32'(recip_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // column sums and line store of horizontal sums
   assign st_raddr = (state_ff == S_ARD) ? {sub_mod(cymod_ff, k2), x_ff}
                                         : {sub_mod(yymod_ff, r1), x_ff};
   assign st_waddr = {cymod_ff, x_ff};

   sbf_ram #(.WIDTH(CW), .DEPTH(MAX_WIDTH)) u_cs_ram (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr ($clog2(MAX_WIDTH)'(x_ff)),
      .wr_data (cs_wdata),
      .rd_addr ($clog2(MAX_WIDTH)'(x_ff)),
      .rd_data (cs_rd)
   );

   sbf_ram #(.WIDTH(HW), .DEPTH(LSD)) u_line_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_AEX),
      .wr_addr ($clog2(LSD)'(st_waddr)),
      .wr_data (hsum_ff),
      .rd_addr ($clog2(LSD)'(st_raddr)),
      .rd_data (st_rd)
   );

   assign lastcol  = (WCW'(col_ff) + WCW'(1)) == w_eff;
   assign lastrow  = (sbf_pkg::DIM_W'(row_ff) + sbf_pkg::DIM_W'(1)) == h_eff;
   assign col_ge_r = 32'(col_ff) >= 32'(radius_ff);
   assign row_ge_r = 32'(row_ff) >= 32'(radius_ff);
   assign x0_acc   = col_ge_r ? col_ff - XW'(radius_ff) : '0;
   assign y0_acc   = row_ge_r ? row_ff - YW'(radius_ff) : '0;

   assign prod = PRW'(plo_ff) + (PRW'(phi_ff) << LOW) + (PRW'(1) << (FRAC_SH - 1));
   assign quo  = prod[PRW-1:FRAC_SH];

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      recip_in  = recip_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ymod_in   = ymod_ff;
      hsum_in   = hsum_ff;
      taps_in   = taps_ff;
      cy_in     = cy_ff;
      cymod_in  = cymod_ff;
      x_in      = x_ff;
      x0_in     = x0_ff;
      x1_in     = x1_ff;
      d_in      = d_ff;
      yy_in     = yy_ff;
      yymod_in  = yymod_ff;
      y0_in     = y0_ff;
      y0mod_in  = y0mod_ff;
      y1_in     = y1_ff;
      rows_in   = rows_ff;
      csv_in    = csv_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      cs_we     = 1'b0;
      cs_wdata  = '0;

      if (cfg_wr) begin
         unique case (reg_index_cast(csr_paddr[3:2]))
            sbf_pkg::REG_WIDTH:  width_in  = csr_pwdata[sbf_pkg::DIM_W-1:0];
            sbf_pkg::REG_HEIGHT: height_in = csr_pwdata[sbf_pkg::DIM_W-1:0];
            sbf_pkg::REG_RADIUS: radius_in = csr_pwdata[sbf_pkg::RAD_W-1:0];
            sbf_pkg::REG_RECIP:  recip_in  = csr_pwdata[sbf_pkg::RECIP_W-1:0];
            default: ;
         endcase
         col_in  = '0;
         row_in  = '0;
         ymod_in = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // horizontal running sum; leaving pixel is 2r+1 columns back
               if (col_ff == '0) begin
                  hsum_in = HW'(px);
               end else if (32'(col_ff) >= 32'(k2)) begin
                  hsum_in = hsum_ff + HW'(px) - HW'(taps_ff[WW'({radius_ff, 1'b0})]);
               end else begin
                  hsum_in = hsum_ff + HW'(px);
               end
               taps_in[0] = px;
               for (int i = 1; i < WIN; i++) begin
                  taps_in[i] = taps_ff[i-1];
               end
               cy_in    = row_ff;
               cymod_in = ymod_ff;
               x0_in    = x0_acc;
               x_in     = x0_acc;
               x1_in    = lastcol ? col_ff : x0_acc;
               d_in     = 3'(col_ff - x0_acc);
               y0_in    = y0_acc;
               y0mod_in = row_ge_r ? sub_mod(ymod_ff, 4'(radius_ff)) : '0;
               y1_in    = lastrow ? row_ff : y0_acc;
               rows_in  = lastrow || row_ge_r;
               if (lastcol || col_ge_r) begin
                  state_in = S_ARD;
               end
               if (lastcol) begin
                  col_in = '0;
                  if (lastrow) begin
                     row_in  = '0;
                     ymod_in = '0;
                  end else begin
                     row_in  = row_ff + YW'(1);
                     ymod_in = (ymod_ff == WW'(WIN - 1)) ? '0 : ymod_ff + WW'(1);
                  end
               end else begin
                  col_in = col_ff + XW'(1);
               end
            end
         end
         S_ARD: begin
            // at row end, drop pixels left of this column's window
            if ((32'(d_ff) < 32'(radius_ff)) && (32'(x_ff) >= 32'(r1))) begin
               hsum_in = hsum_ff - HW'(taps_ff[WW'(4'(d_ff) + r1)]);
            end
            state_in = S_AEX;
         end
         S_AEX: begin
            cs_we = 1'b1;
            if (cy_ff == '0) begin
               cs_wdata = CW'(hsum_ff);
            end else if (32'(cy_ff) >= 32'(k2)) begin
               cs_wdata = cs_rd + CW'(hsum_ff) - CW'(st_rd);
            end else begin
               cs_wdata = cs_rd + CW'(hsum_ff);
            end
            if (x_ff == x1_ff) begin
               x_in     = x0_ff;
               yy_in    = y0_ff;
               yymod_in = y0mod_ff;
               state_in = rows_ff ? S_BRD : S_IDLE;
            end else begin
               x_in     = x_ff + XW'(1);
               d_in     = d_ff - 3'd1;
               state_in = S_ARD;
            end
         end
         S_BRD: begin
            state_in = S_BEX;
         end
         S_BEX: begin
            cs_we = 1'b1;
            if ((32'(yy_ff) + 32'(radius_ff) > 32'(cy_ff)) &&
                (32'(yy_ff) >= 32'(r1))) begin
               cs_wdata = cs_rd - CW'(st_rd);
            end else begin
               cs_wdata = cs_rd;
            end
            csv_in   = cs_wdata;
            state_in = S_BMUL;
         end
         S_BMUL: begin
            plo_in   = csv_ff * recip_ff[LOW-1:0];
            phi_in   = csv_ff * recip_ff[sbf_pkg::RECIP_W-1:LOW];
            state_in = S_BOUT;
         end
         S_BOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[15:0]  = (|quo[PRW-FRAC_SH-1:PW]) ? '1 : quo[PW-1:0];
               rsp_data_in[25:16] = YW'(x_ff);
               rsp_data_in[35:26] = yy_ff;
               rsp_last_in  = (x_ff == x1_ff) && (yy_ff == y1_ff);
               rsp_user_in  = (WCW'(x_ff) + WCW'(1) == w_eff) &&
                              (sbf_pkg::DIM_W'(yy_ff) + sbf_pkg::DIM_W'(1) == h_eff);
               if (x_ff == x1_ff) begin
                  if (yy_ff == y1_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     x_in     = x0_ff;
                     yy_in    = yy_ff + YW'(1);
                     yymod_in = (yymod_ff == WW'(WIN - 1)) ? '0 : yymod_ff + WW'(1);
                     state_in = S_BRD;
                  end
               end else begin
                  x_in     = x_ff + XW'(1);
                  state_in = S_BRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= sbf_pkg::WIDTH_RESET;
         height_ff    <= sbf_pkg::HEIGHT_RESET;
         radius_ff    <= sbf_pkg::RADIUS_RESET;
         recip_ff     <= sbf_pkg::RECIP_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         ymod_ff      <= '0;
         hsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         recip_ff     <= recip_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ymod_ff      <= ymod_in;
         hsum_ff      <= hsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      taps_ff     <= taps_in;
      cy_ff       <= cy_in;
      cymod_ff    <= cymod_in;
      x_ff        <= x_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      d_ff        <= d_in;
      yy_ff       <= yy_in;
      yymod_ff    <= yymod_in;
      y0_ff       <= y0_in;
      y0mod_ff    <= y0mod_in;
      y1_ff       <= y1_in;
      rows_ff     <= rows_in;
      csv_ff      <= csv_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule
